FILE: sv/dra_pkg.sv
// Shared types and constants for the descriptor range allocator.
`timescale 1ns / 1ps
package dra_pkg;

	localparam int RANGE_SLOTS    = 64;
	localparam int SLOT_W         = $clog2(RANGE_SLOTS);
	localparam int CNT_W          = SLOT_W + 1;
	localparam int MIN_HEAP_BYTES = 4096;

	localparam logic [31:0] NO_INDEX = 32'hFFFF_FFFF;

	localparam logic [8:0]  DESC_SIZE_RST = 9'd32;
	localparam logic [31:0] HEAP_MAX_RST  = 32'd16777216;
	localparam logic [20:0] RESERVE_RST   = 21'd0;

	typedef enum logic [1:0] {
		CFG_DESC_SIZE = 2'd0,
		CFG_HEAP_MAX  = 2'd1,
		CFG_RESERVE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OOM       = 3'd1,
		ST_BAD_FREE  = 3'd2,
		ST_IGNORED   = 3'd3,
		ST_LIST_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		RD_PTR,
		RD_NEXT,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_FIT,
		WR_SHIFT,
		WR_TAIL,
		WR_MERGE,
		WR_PUT
	} wr_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CALC,
		S_DISPATCH,
		S_A_RD,
		S_A_CHK,
		S_DROP_RD,
		S_DROP_WR,
		S_A_NOFIT,
		S_RES_WAIT,
		S_NEED,
		S_CHKMAX,
		S_POW,
		S_GROW,
		S_DIV_GO,
		S_DIV_WAIT,
		S_F_RANGE,
		S_F_RD,
		S_F_CHK,
		S_F_DECIDE,
		S_INS_RD,
		S_INS_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    load;
		logic    calc;
		logic    ptr_clr;
		logic    ptr_inc;
		logic    ptr_dec;
		logic    ptr_set_cnt;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    pos_clr;
		logic    pos_chk;
		logic    cap_fit;
		logic    cap_base;
		logic    div_start;
		logic    div_res;
		logic    base_set;
		logic    need_set;
		logic    pow_clr;
		logic    pow_step;
		logic    size_set;
		logic    grow;
		logic    res_set;
		status_t res_code;
		logic    res_grew;
		logic    res_use_quot;
		logic    finish;
	} dra_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic kind_free;
		logic sentinel;
		logic scan_done;
		logic fit;
		logic fit_exact;
		logic drop_done;
		logic heap_zero;
		logic need_gt_max;
		logic pow_lt;
		logic tail_nonempty;
		logic cnt_full;
		logic hi_gt_heap;
		logic overlap;
		logic pos_match;
		logic ins_done;
		logic div_done;
		logic out_free;
	} dra_stat_t;

endpackage

FILE: sv/dra_div.sv
// Iterative restoring divider, 32-bit dividend by 9-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module dra_div
	import dra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [8:0]  divisor,
	output logic [31:0] quot,
	output logic        done
);

	logic [31:0] quot_q;
	logic [8:0]  rem_q;
	logic [8:0]  dvs_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [9:0]  trial;
	logic        take;

	assign trial = {rem_q, quot_q[31]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[30:0], take};
			rem_q  <= take ? 9'(trial - {1'b0, dvs_q}) : trial[8:0];
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

FILE: sv/dra_datapath.sv
// Datapath: config registers, range memory, byte arithmetic and result register.
`timescale 1ns / 1ps
module dra_datapath
	import dra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        kind,
	input  logic [15:0] element_count,
	input  logic [31:0] element_index,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [31:0] result_index,
	output logic [2:0]  status,
	output logic [31:0] heap_bytes,
	output logic        grew,
	input  dra_cmd_t    cmd,
	output dra_stat_t   stat
);

	logic [8:0]  dsize_q;
	logic [31:0] hmax_q;
	logic [20:0] reserve_q;

	logic        kind_q;
	logic [15:0] count_q;
	logic [31:0] index_q;
	logic [24:0] bytes_q;
	logic [40:0] lo_q;
	logic [41:0] hi;

	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_q;
	logic             pos_found_q;
	logic [31:0]      pos_start_q;
	logic [31:0]      pos_stop_q;

	logic [63:0] mem [RANGE_SLOTS];
	logic [63:0] rdata_q;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;
	logic [63:0] wr_data;
	logic [31:0] r_start;
	logic [31:0] r_stop;
	logic [32:0] fit_end;

	logic [31:0] heap_q;
	logic [32:0] base_q;
	logic [32:0] need_q;
	logic [33:0] pow_q;
	logic [31:0] size_q;
	logic [33:0] pow_min;
	logic [31:0] dvd_q;

	logic [8:0]  el;
	logic [31:0] div_dvd;
	logic [31:0] div_quot;
	logic        div_done;

	logic [31:0] res_idx_q;
	status_t     res_code_q;
	logic        res_grew_q;

	logic        out_valid_q;
	logic [31:0] out_idx_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_heap_q;
	logic        out_grew_q;

	assign el      = (dsize_q == 9'd0) ? 9'd1 : dsize_q;
	assign hi      = {1'b0, lo_q} + 42'(bytes_q);
	assign r_start = rdata_q[63:32];
	assign r_stop  = rdata_q[31:0];
	assign fit_end = {1'b0, r_start} + 33'(bytes_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsize_q   <= DESC_SIZE_RST;
			hmax_q    <= HEAP_MAX_RST;
			reserve_q <= RESERVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DESC_SIZE: dsize_q   <= cfg_wdata[8:0];
				CFG_HEAP_MAX:  hmax_q    <= cfg_wdata;
				CFG_RESERVE:   reserve_q <= cfg_wdata[20:0];
				default: ;
			endcase
		end
	end

	// request payload and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			count_q <= element_count;
			index_q <= element_index;
		end
		if (cmd.calc) begin
			bytes_q <= 25'(count_q * el);
			lo_q    <= 41'(index_q * el);
		end
		if (cmd.pos_chk && !pos_found_q && ({10'd0, r_start} >= hi)) begin
			pos_start_q <= r_start;
			pos_stop_q  <= r_stop;
		end
		if (cmd.cap_fit)
			dvd_q <= r_start;
		else if (cmd.cap_base)
			dvd_q <= base_q[31:0];
		if (cmd.base_set)
			base_q <= (heap_q != 32'd0) ? {1'b0, heap_q} : 33'(div_quot[21:0] * el);
		if (cmd.need_set)
			need_q <= base_q + 33'(bytes_q);
		if (cmd.pow_clr)
			pow_q <= 34'd1;
		else if (cmd.pow_step)
			pow_q <= {pow_q[32:0], 1'b0};
		if (cmd.size_set)
			size_q <= (pow_min > {2'b0, hmax_q}) ? hmax_q : pow_min[31:0];
		if (cmd.res_set) begin
			res_code_q <= cmd.res_code;
			res_grew_q <= cmd.res_grew;
			res_idx_q  <= cmd.res_use_quot ? div_quot : 32'd0;
		end
	end

	assign pow_min = (pow_q < 34'(MIN_HEAP_BYTES)) ? 34'(MIN_HEAP_BYTES) : pow_q;

	// list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			pos_found_q <= 1'b0;
			heap_q      <= '0;
		end else begin
			if (cmd.ptr_clr)
				ptr_q <= '0;
			else if (cmd.ptr_inc)
				ptr_q <= ptr_q + 1'b1;
			else if (cmd.ptr_dec)
				ptr_q <= ptr_q - 1'b1;
			else if (cmd.ptr_set_cnt)
				ptr_q <= cnt_q;
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.pos_clr) begin
				pos_q       <= cnt_q;
				pos_found_q <= 1'b0;
			end else if (cmd.pos_chk && !pos_found_q && ({10'd0, r_start} >= hi)) begin
				pos_q       <= ptr_q;
				pos_found_q <= 1'b1;
			end
			if (cmd.grow)
				heap_q <= size_q;
		end
	end

	// range memory: {start, stop} per slot
	always_comb begin
		case (cmd.rd_sel)
			RD_NEXT: rd_addr = SLOT_W'(ptr_q + 1'b1);
			RD_PREV: rd_addr = SLOT_W'(ptr_q - 1'b1);
			default: rd_addr = ptr_q[SLOT_W-1:0];
		endcase
		case (cmd.wr_sel)
			WR_FIT:   begin wr_addr = ptr_q[SLOT_W-1:0]; wr_data = {fit_end[31:0], r_stop}; end
			WR_TAIL:  begin wr_addr = cnt_q[SLOT_W-1:0]; wr_data = {need_q[31:0], size_q}; end
			WR_MERGE: begin wr_addr = pos_q[SLOT_W-1:0]; wr_data = {lo_q[31:0], pos_stop_q}; end
			WR_PUT:   begin wr_addr = ptr_q[SLOT_W-1:0]; wr_data = {lo_q[31:0], hi[31:0]}; end
			default:  begin wr_addr = ptr_q[SLOT_W-1:0]; wr_data = rdata_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign div_dvd = cmd.div_res ? 32'({1'b0, reserve_q} + 22'(el) - 22'd1) : dvd_q;

	dra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (el),
		.quot     (div_quot),
		.done     (div_done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_idx_q    <= res_idx_q;
			out_status_q <= res_code_q;
			out_heap_q   <= heap_q;
			out_grew_q   <= res_grew_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = out_idx_q;
	assign status       = out_status_q;
	assign heap_bytes   = out_heap_q;
	assign grew         = out_grew_q;

	always_comb begin
		stat               = '0;
		stat.count_zero    = count_q == 16'd0;
		stat.kind_free     = kind_q;
		stat.sentinel      = index_q == NO_INDEX;
		stat.scan_done     = ptr_q >= cnt_q;
		stat.fit           = fit_end <= {1'b0, r_stop};
		stat.fit_exact     = fit_end == {1'b0, r_stop};
		stat.drop_done     = ({1'b0, ptr_q} + 1'b1) >= {1'b0, cnt_q};
		stat.heap_zero     = heap_q == 32'd0;
		stat.need_gt_max   = need_q > {1'b0, hmax_q};
		stat.pow_lt        = pow_q < {1'b0, need_q};
		stat.tail_nonempty = need_q < {1'b0, size_q};
		stat.cnt_full      = cnt_q >= CNT_W'(RANGE_SLOTS);
		stat.hi_gt_heap    = hi > {10'd0, heap_q};
		stat.overlap       = (lo_q < {9'd0, r_stop}) && ({10'd0, r_start} < hi);
		stat.pos_match     = pos_found_q && ({10'd0, pos_start_q} == hi);
		stat.ins_done      = ptr_q <= pos_q;
		stat.div_done      = div_done;
		stat.out_free      = !out_valid_q || !out_stall;
	end

endmodule

FILE: sv/dra_ctrl.sv
// Controller state machine sequencing scans, list shifts, growth and division.
`timescale 1ns / 1ps
module dra_ctrl
	import dra_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dra_stat_t stat,
	output dra_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   grew_q, grew_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grew_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			grew_q  <= grew_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		grew_d  = grew_q;
		cmd     = '0;
		cmd.res_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					grew_d   = 1'b0;
					state_d  = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (stat.count_zero || (stat.kind_free && stat.sentinel)) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_IGNORED;
					state_d      = S_FIN;
				end else if (stat.kind_free) begin
					state_d = S_F_RANGE;
				end else begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_A_RD;
				end
			end
			S_A_RD: begin
				if (stat.scan_done) begin
					state_d = S_A_NOFIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR;
					state_d    = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.fit) begin
					cmd.cap_fit = 1'b1;
					if (stat.fit_exact) begin
						state_d = S_DROP_RD;
					end else begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_FIT;
						state_d    = S_DIV_GO;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_A_RD;
				end
			end
			S_DROP_RD: begin
				if (stat.drop_done) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DIV_GO;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_DROP_WR;
				end
			end
			S_DROP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_inc = 1'b1;
				state_d     = S_DROP_RD;
			end
			S_A_NOFIT: begin
				if (stat.heap_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_res   = 1'b1;
					state_d       = S_RES_WAIT;
				end else begin
					cmd.base_set = 1'b1;
					state_d      = S_NEED;
				end
			end
			S_RES_WAIT: begin
				if (stat.div_done) begin
					cmd.base_set = 1'b1;
					state_d      = S_NEED;
				end
			end
			S_NEED: begin
				cmd.need_set = 1'b1;
				cmd.pow_clr  = 1'b1;
				state_d      = S_CHKMAX;
			end
			S_CHKMAX: begin
				if (stat.need_gt_max) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OOM;
					state_d      = S_FIN;
				end else begin
					state_d = S_POW;
				end
			end
			S_POW: begin
				if (stat.pow_lt) begin
					cmd.pow_step = 1'b1;
				end else begin
					cmd.size_set = 1'b1;
					state_d      = S_GROW;
				end
			end
			S_GROW: begin
				if (stat.tail_nonempty && stat.cnt_full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_LIST_FULL;
					state_d      = S_FIN;
				end else begin
					if (stat.tail_nonempty) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_TAIL;
						cmd.cnt_inc = 1'b1;
					end
					cmd.grow     = 1'b1;
					cmd.cap_base = 1'b1;
					grew_d       = 1'b1;
					state_d      = S_DIV_GO;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.res_set      = 1'b1;
					cmd.res_code     = ST_OK;
					cmd.res_use_quot = 1'b1;
					cmd.res_grew     = grew_q;
					state_d          = S_FIN;
				end
			end
			S_F_RANGE: begin
				if (stat.hi_gt_heap) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_BAD_FREE;
					state_d      = S_FIN;
				end else begin
					cmd.ptr_clr = 1'b1;
					cmd.pos_clr = 1'b1;
					state_d     = S_F_RD;
				end
			end
			S_F_RD: begin
				if (stat.scan_done) begin
					state_d = S_F_DECIDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR;
					state_d    = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (stat.overlap) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_BAD_FREE;
					state_d      = S_FIN;
				end else begin
					cmd.pos_chk = 1'b1;
					cmd.ptr_inc = 1'b1;
					state_d     = S_F_RD;
				end
			end
			S_F_DECIDE: begin
				if (stat.pos_match) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_MERGE;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_d      = S_FIN;
				end else if (stat.cnt_full) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_LIST_FULL;
					state_d      = S_FIN;
				end else begin
					cmd.ptr_set_cnt = 1'b1;
					state_d         = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (stat.ins_done) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_PUT;
					cmd.cnt_inc  = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_d      = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d    = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.ptr_dec = 1'b1;
				state_d     = S_INS_RD;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: sv/descriptor_range_allocator_top.sv
// Top level of the first-fit descriptor range allocator.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on in_valid/in_stall with kind, element_count and
//   element_index; one result transaction per request leaves on
//   out_valid/out_stall with result_index, status, heap_bytes and grew.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; the user
//   must write them only while idle, which the block does not enforce.
// Sequencing:
//   One request at a time. The range list has one registered read port, so
//   each scanned range takes a read and a check, and each shifted range a
//   read and a write. An alloc that fits takes its index from the
//   bit-serial index divider, and when that range empties the ranges after
//   it shift down. An alloc that grows takes at most 32 doublings to the new
//   size, plus a reserve rounding division on the first growth. A free
//   joins the next range, or inserts a new one and shifts ranges up.
// Reset: the range list and heap size are emptied, registers take their
//   defaults; no clearing pass is needed.
// Stall: a finished result sits in an output register; the next request is
//   accepted meanwhile, and only its own completion waits for that slot.
module descriptor_range_allocator_top
	import dra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] element_count,
	input  logic [31:0] element_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_index,
	output logic [2:0]  status,
	output logic [31:0] heap_bytes,
	output logic        grew
);

	dra_cmd_t  cmd;
	dra_stat_t stat;

	dra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dra_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.element_count (element_count),
		.element_index (element_index),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result_index  (result_index),
		.status        (status),
		.heap_bytes    (heap_bytes),
		.grew          (grew),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

FILE: tb/sv/dra_alloc_checker.sv
// Checker for the descriptor range allocator: predicts each result and compares.
`timescale 1ns / 1ps
module dra_alloc_checker
	import dra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic [15:0] element_count,
	input  logic [31:0] element_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_index,
	input  logic [2:0]  status,
	input  logic [31:0] heap_bytes,
	input  logic        grew,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          grow_count
);

	typedef struct {
		logic [31:0] idx;
		status_t     st;
		logic [31:0] heap;
		logic        grew;
	} alloc_result_t;

	// predictor copy of the configuration and the free-range list
	logic [8:0]  desc_size;
	logic [31:0] heap_max;
	logic [20:0] reserve;
	logic [31:0] free_lo [RANGE_SLOTS];
	logic [31:0] free_hi [RANGE_SLOTS];
	int          free_n;
	logic [31:0] heap_now;

	alloc_result_t awaited_results[$];

	task automatic drop_slot(input int k);
		for (int j = k; j + 1 < free_n; j++) begin
			free_lo[j] = free_lo[j + 1];
			free_hi[j] = free_hi[j + 1];
		end
		free_n--;
	endtask

	task automatic put_slot(input int k, input logic [31:0] lo, input logic [31:0] hi);
		for (int j = free_n; j > k; j--) begin
			free_lo[j] = free_lo[j - 1];
			free_hi[j] = free_hi[j - 1];
		end
		free_lo[k] = lo;
		free_hi[k] = hi;
		free_n++;
	endtask

	task automatic model_request(input logic k, input logic [15:0] cnt, input logic [31:0] ptr,
			output alloc_result_t r);
		longint unsigned el, bytes, rsv, base, need, sz, lo, hi;
		int hit;
		int pos;
		r.idx  = '0;
		r.grew = 1'b0;
		r.st   = ST_OK;
		el     = (desc_size == 0) ? 64'd1 : 64'(desc_size);
		bytes  = 64'(cnt) * el;
		if (cnt == 0) begin
			r.st = ST_IGNORED;
		end else if (!k) begin
			hit = -1;
			for (int i = 0; i < free_n; i++)
				if (hit < 0 && 64'(free_lo[i]) + bytes <= 64'(free_hi[i]))
					hit = i;
			if (hit >= 0) begin
				r.idx = 32'(64'(free_lo[hit]) / el);
				free_lo[hit] = 32'(64'(free_lo[hit]) + bytes);
				if (free_lo[hit] == free_hi[hit])
					drop_slot(hit);
			end else begin
				rsv  = (64'(reserve) + el - 1) / el * el;
				base = (heap_now != 0) ? 64'(heap_now) : rsv;
				need = base + bytes;
				if (need > 64'(heap_max)) begin
					r.st = ST_OOM;
				end else begin
					sz = 1;
					while (sz < need)
						sz = sz << 1;
					if (sz < MIN_HEAP_BYTES)
						sz = MIN_HEAP_BYTES;
					if (sz > 64'(heap_max))
						sz = 64'(heap_max);
					if (need < sz && free_n >= RANGE_SLOTS) begin
						r.st = ST_LIST_FULL;
					end else begin
						if (need < sz)
							put_slot(free_n, 32'(need), 32'(sz));
						r.idx    = 32'(base / el);
						heap_now = 32'(sz);
						r.grew   = 1'b1;
					end
				end
			end
		end else if (ptr == NO_INDEX) begin
			r.st = ST_IGNORED;
		end else begin
			lo = 64'(ptr) * el;
			hi = lo + bytes;
			if (hi > 64'(heap_now))
				r.st = ST_BAD_FREE;
			for (int i = 0; i < free_n; i++)
				if (lo < 64'(free_hi[i]) && 64'(free_lo[i]) < hi)
					r.st = ST_BAD_FREE;
			if (r.st == ST_OK) begin
				pos = free_n;
				for (int i = free_n - 1; i >= 0; i--)
					if (64'(free_lo[i]) >= hi)
						pos = i;
				if (pos < free_n && 64'(free_lo[pos]) == hi)
					free_lo[pos] = 32'(lo);
				else if (free_n >= RANGE_SLOTS)
					r.st = ST_LIST_FULL;
				else
					put_slot(pos, 32'(lo), 32'(hi));
			end
		end
		if (r.st != ST_OK) begin
			r.idx  = '0;
			r.grew = 1'b0;
		end
		r.heap = heap_now;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t checker: %s got 0x%08h expected 0x%08h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t r;
		if (!arst_n) begin
			desc_size  = DESC_SIZE_RST;
			heap_max   = HEAP_MAX_RST;
			reserve    = RESERVE_RST;
			free_n     = 0;
			heap_now   = '0;
			fail_count = 0;
			checked    = 0;
			grow_count = 0;
			awaited_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DESC_SIZE: desc_size = cfg_wdata[8:0];
					CFG_HEAP_MAX:  heap_max  = cfg_wdata;
					CFG_RESERVE:   reserve   = cfg_wdata[20:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited, index", result_index, '0);
				end else begin
					r = awaited_results.pop_front();
					checked++;
					if (result_index !== r.idx)
						report_mismatch("result_index", result_index, r.idx);
					if (status !== r.st)
						report_mismatch("status", 32'(status), 32'(r.st));
					if (heap_bytes !== r.heap)
						report_mismatch("heap_bytes", heap_bytes, r.heap);
					if (grew !== r.grew)
						report_mismatch("grew", 32'(grew), 32'(r.grew));
				end
			end
			if (in_valid && !in_stall) begin
				model_request(kind, element_count, element_index, r);
				if (r.grew)
					grow_count++;
				awaited_results.insert(awaited_results.size(), r);
			end
		end
		pending <= awaited_results.size();
	end

endmodule

FILE: tb/sv/tb_descriptor_range_allocator_top.sv
// Testbench top for the descriptor range allocator: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module tb_descriptor_range_allocator_top;
	import dra_pkg::*;

	localparam int ITEMS_PER_PHASE = 170;
	localparam int NUM_PHASES      = 6;
	localparam int DRAIN_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT  = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [15:0] element_count;
	logic [31:0] element_index;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result_index;
	logic [2:0]  status;
	logic [31:0] heap_bytes;
	logic        grew;

	int fail_count, pending, checked, grow_count;

	descriptor_range_allocator_top i_dut (.*);

	dra_alloc_checker i_checker (.*);

	// a live block is an allocation (or what is left of one) not yet freed
	typedef struct {
		logic [31:0] idx;
		int          cnt;
	} live_block_t;

	typedef struct {
		logic kind;
		int   cnt;
		int   epoch;
	} sent_req_t;

	live_block_t live_blocks[$];
	sent_req_t   in_flight[$];
	live_block_t last_freed;
	int          size_epoch;    // bumps whenever descriptor_size changes
	int          burst_left;
	int          alloc_cap;
	int          n_sent;
	int          idle_cycles;

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_DESC_SIZE;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		kind          = 1'b0;
		element_count = '0;
		element_index = '0;
		out_stall     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// receiver: stall pattern switches at random between three modes
	// (none / short random stalls / long stalls)
	// ------------------------------------------------------------------
	int stall_mode, stall_left, stall_cyc;

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cyc++;
			if (stall_cyc % 600 == 0)
				stall_mode = $urandom_range(0, 2);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (stall_mode == 1 && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 3);
				else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
					stall_left = $urandom_range(5, 40);
			end
		end
	end

	// ------------------------------------------------------------------
	// result tracking: successful allocations become live blocks that
	// the stimulus may free later; stale ones (old element size) dropped
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sent_req_t q;
		if (arst_n && out_valid && !out_stall && in_flight.size() != 0) begin
			q = in_flight.pop_front();
			if (!q.kind && status == ST_OK && q.epoch == size_epoch)
				live_blocks.insert(live_blocks.size(), '{result_index, q.cnt});
		end
	end

	// watchdog: cycles with no transaction on either channel and no register write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// sender: one request per call, bursts with random gaps between them
	// ------------------------------------------------------------------
	task automatic send_request(input logic k, input logic [15:0] cnt, input logic [31:0] ptr);
		int gap;
		in_valid      <= 1'b1;
		kind          <= k;
		element_count <= cnt;
		element_index <= ptr;
		// in_stall is settled mid-cycle; when low the next edge takes the transaction
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		in_flight.insert(in_flight.size(), '{k, int'(cnt), size_epoch});
		n_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// all results back, then let the block settle before touching registers
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// free a random piece of a live block; the remainders stay live
	task automatic free_live_piece();
		live_block_t b;
		int j, off, len;
		j = $urandom_range(0, live_blocks.size() - 1);
		b = live_blocks[j];
		live_blocks.delete(j);
		if ($urandom_range(0, 1)) begin
			off = 0;
			len = b.cnt;
		end else begin
			off = $urandom_range(0, b.cnt - 1);
			len = $urandom_range(1, b.cnt - off);
		end
		if (off > 0)
			live_blocks.insert(live_blocks.size(), '{b.idx, off});
		if (off + len < b.cnt)
			live_blocks.insert(live_blocks.size(),
				'{b.idx + 32'(off + len), b.cnt - off - len});
		last_freed = '{b.idx + 32'(off), len};
		send_request(1'b1, 16'(len), b.idx + 32'(off));
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			send_request(1'($urandom_range(0, 1)), 16'd0, $urandom());
		else if (pick < 5)
			send_request(1'b1, 16'($urandom_range(1, 65535)), NO_INDEX);
		else if (pick < 10)
			send_request(1'b1, 16'($urandom()), $urandom());
		else if (pick < 14 && last_freed.cnt > 0)
			// freeing the same block twice overlaps a free range
			send_request(1'b1, 16'(last_freed.cnt), last_freed.idx);
		else if (pick < 55 && live_blocks.size() != 0)
			free_live_piece();
		else if (pick < 58)
			send_request(1'b0, 16'($urandom()), $urandom());
		else
			send_request(1'b0, 16'($urandom_range(1, alloc_cap)), $urandom());
	endtask

	// ------------------------------------------------------------------
	// main sequence: register settings per phase, directed opening,
	// then random traffic
	// ------------------------------------------------------------------
	logic [31:0] ph_size [NUM_PHASES] = '{32'd24, 32'd1, 32'd256, 32'd0, 32'd7, 32'h1FF};
	logic [31:0] ph_max  [NUM_PHASES] = '{32'h0010_0000, 32'hFFFF_FFFF, 32'd16777216,
		32'd4096, 32'h0200_0000, 32'hFFFF_FFFF};
	logic [31:0] ph_rsv  [NUM_PHASES] = '{32'd1000, 32'd1048576, 32'd0,
		32'h001F_FFFF, 32'd13, 32'd0};
	int          ph_cap  [NUM_PHASES] = '{16, 64, 4, 8, 2, 32};

	initial begin
		burst_left = 1;
		@(posedge arst_n);
		@(posedge clk);
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			// reserve only shapes the first growth, so phase 0 sets it before any request
			write_reg(CFG_DESC_SIZE, ph_size[p]);
			write_reg(CFG_HEAP_MAX, ph_max[p]);
			write_reg(CFG_RESERVE, ph_rsv[p]);
			cfg_we <= 1'b0;
			@(posedge clk);
			size_epoch++;
			live_blocks.delete();
			last_freed = '{'0, 0};
			alloc_cap  = ph_cap[p];

			if (p == 0) begin
				// zero counts, sentinel pointer, free before any heap exists
				send_request(1'b0, 16'd0, '0);
				send_request(1'b1, 16'd0, 32'd5);
				send_request(1'b1, 16'd5, NO_INDEX);
				send_request(1'b1, 16'd1, 32'd0);
				// first growth honors the reserve; too large a request runs out of memory
				send_request(1'b0, 16'd1, '0);
				send_request(1'b0, 16'hFFFF, '0);
				send_request(1'b0, 16'd100, '0);
				send_request(1'b0, 16'd40, '0);
				send_request(1'b0, 16'd3, '0);
				wait_drained();
				// free the middle block, free it again (overlap),
				// then two more live blocks, beyond the heap and at the top of the index space
				if (live_blocks.size() >= 4) begin
					send_request(1'b1, 16'(live_blocks[2].cnt), live_blocks[2].idx);
					send_request(1'b1, 16'(live_blocks[2].cnt), live_blocks[2].idx);
					send_request(1'b1, 16'(live_blocks[3].cnt), live_blocks[3].idx);
					send_request(1'b1, 16'd1, live_blocks[0].idx);
					live_blocks.delete(3);
					live_blocks.delete(2);
					live_blocks.delete(0);
				end
				send_request(1'b1, 16'd1, 32'h7FFF_FFFF);
				send_request(1'b1, 16'hFFFF, 32'hFFFF_FFFE);
				// allocate the sizes of the middle and first blocks again, then keep allocating
				send_request(1'b0, 16'd40, '0);
				send_request(1'b0, 16'd1, '0);
				wait_drained();
			end

			// fragmenting phases (cap 4 or less): many one-element blocks, frees to fill the range list, random traffic
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (alloc_cap <= 4 && n < 80)
					send_request(1'b0, 16'd1, '0);
				else if (alloc_cap <= 4 && n < 120 && live_blocks.size() != 0)
					free_live_piece();
				else
					random_request();
			end
		end

		wait_drained();
		$display("run: %0d requests over %0d register settings, %0d results compared",
			n_sent, NUM_PHASES, checked);
		$display("run: %0d heap growths seen, %0d results outstanding at end",
			grow_count, pending);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: descriptor_range_allocator_top.f
sv/dra_pkg.sv
sv/dra_div.sv
sv/dra_datapath.sv
sv/dra_ctrl.sv
sv/descriptor_range_allocator_top.sv
tb/sv/dra_alloc_checker.sv
tb/sv/tb_descriptor_range_allocator_top.sv
